// File: hw/rtl/t5ss_pkg.sv
// ----------------------------------------------------------------------------
// t5ss_pkg: shared types and constants for the top-5 score selector
// Input and result word layouts, slot width constants.
// ----------------------------------------------------------------------------
package t5ss_pkg;

	localparam int ScoreW = 32;
	localparam int PosW   = 16;

	typedef struct packed {
		logic [31:0] score_bits;
		logic        first_of_vector;
		logic        last_of_vector;
	} in_word_t;

	typedef struct packed {
		logic [15:0] rank1_pos;
		logic [15:0] rank2_pos;
		logic [15:0] rank3_pos;
		logic [15:0] rank4_pos;
		logic [15:0] rank5_pos;
		logic [31:0] rank1_score;
		logic [31:0] rank2_score;
		logic [31:0] rank3_score;
		logic [31:0] rank4_score;
		logic [31:0] rank5_score;
	} out_word_t;

	// one slot: score bits and the position where it appeared
	typedef struct packed {
		logic [ScoreW-1:0] score;
		logic [PosW-1:0]   pos;
	} slot_t;

	// ordered IEEE single greater-than: NaN never wins, -0 == +0
	function automatic logic fp_gt(input logic [ScoreW-1:0] a, input logic [ScoreW-1:0] b);
		logic a_nan;
		logic b_nan;
		logic a_zero;
		logic b_zero;
		logic res;
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
		a_zero = (a[30:0] == '0);
		b_zero = (b[30:0] == '0);
		if (a_nan || b_nan || (a_zero && b_zero)) begin
			res = 1'b0;
		end else if (a[31] != b[31]) begin
			res = b[31];
		end else if (!a[31]) begin
			res = a[30:0] > b[30:0];
		end else begin
			res = a[30:0] < b[30:0];
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/t5ss_cell.sv
// ----------------------------------------------------------------------------
// t5ss_cell: one rank slot of the insertion chain
// Compares the word's score with the slot; on a win the slot takes the carried
// pair and hands its old pair to the next cell.
// ----------------------------------------------------------------------------
module t5ss_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          first,
	input  logic [t5ss_pkg::ScoreW-1:0]   score,
	input  t5ss_pkg::slot_t               carry_in,
	output t5ss_pkg::slot_t               carry_out,
	output t5ss_pkg::slot_t               slot_d
);

	t5ss_pkg::slot_t slot_q;
	t5ss_pkg::slot_t cur;
	logic            take;

	// a first word sees every slot as already refilled with its own score
	always_comb begin
		cur = slot_q;
		if (first) begin
			cur.score = score;
			cur.pos   = '0;
		end
	end

	// compare the incoming score itself, not the carried one
	assign take      = t5ss_pkg::fp_gt(score, cur.score);
	assign carry_out = take ? cur : carry_in;
	assign slot_d    = take ? carry_in : cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (en) begin
			slot_q <= slot_d;
		end
	end

endmodule

// File: hw/rtl/top5_score_select_unit.sv
// ----------------------------------------------------------------------------
// top5_score_select_unit: streaming top-RANKS selector over float scores
// Row of rank cells with a position counter and an output register.
// ----------------------------------------------------------------------------
// channel | dir | word        | handshake
// in      | in  | in_word_t   | in_valid / in_ready
// out     | out | out_word_t  | out_valid / out_ready
// One score per cycle; all RANKS compares against the incoming score run in
// parallel, and the carried pair ripples through RANKS muxes in that cycle.
// A last word loads the output register in that cycle; result shows next cycle.
// Input stalls only while a result sits unaccepted and another last word comes.
// Reset clears slots, counter and output valid.
// ----------------------------------------------------------------------------
module top5_score_select_unit #(
	parameter int MAX_VECTOR_LEN = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  t5ss_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output t5ss_pkg::out_word_t out_data
);

	localparam int Ranks = 5;
	localparam logic [t5ss_pkg::PosW-1:0] PosMax =
		(MAX_VECTOR_LEN - 1 > 65535) ? 16'hFFFF : t5ss_pkg::PosW'(MAX_VECTOR_LEN - 1);

	logic                        acc;
	logic [t5ss_pkg::PosW-1:0]   pos_q;
	logic [t5ss_pkg::PosW-1:0]   pos_now;
	t5ss_pkg::slot_t             chain [Ranks+1];
	t5ss_pkg::slot_t             nxt   [Ranks];

	assign in_ready = !out_valid || out_ready || !in_data.last_of_vector;
	assign acc      = in_valid && in_ready;
	assign pos_now  = in_data.first_of_vector ? '0 : pos_q;

	assign chain[0].score = in_data.score_bits;
	assign chain[0].pos   = pos_now;

	for (genvar g = 0; g < Ranks; g++) begin : g_cell
		t5ss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (acc),
			.first    (in_data.first_of_vector),
			.score    (in_data.score_bits),
			.carry_in (chain[g]),
			.carry_out(chain[g+1]),
			.slot_d   (nxt[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= (pos_now < PosMax) ? pos_now + 1'b1 : pos_now;
			end
			if (acc && in_data.last_of_vector) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (acc && in_data.last_of_vector) begin
			out_data.rank1_pos   <= nxt[0].pos;
			out_data.rank2_pos   <= nxt[1].pos;
			out_data.rank3_pos   <= nxt[2].pos;
			out_data.rank4_pos   <= nxt[3].pos;
			out_data.rank5_pos   <= nxt[4].pos;
			out_data.rank1_score <= nxt[0].score;
			out_data.rank2_score <= nxt[1].score;
			out_data.rank3_score <= nxt[2].score;
			out_data.rank4_score <= nxt[3].score;
			out_data.rank5_score <= nxt[4].score;
		end
	end

endmodule

// File: hw/rtl/t5ss_checker.sv
// ----------------------------------------------------------------------------
// t5ss_checker: port-level checks for the top-5 score selector
// Watches the handshakes and result word over time.
// ----------------------------------------------------------------------------
module t5ss_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input t5ss_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input t5ss_pkg::out_word_t out_data
);

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_of_vector |=> out_valid)
		else $error("last word gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready && in_data.last_of_vector) |=> !out_valid)
		else $error("result without last word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_ready_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_data.last_of_vector |-> in_ready)
		else $error("non-last word stalled");

endmodule

bind top5_score_select_unit t5ss_checker u_t5ss_checker (.*);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for top5_score_select_unit
// Streams score vectors through the selector and checks every ranked result
// against an in-bench top-5 predictor with the ordered float compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int NumRanks = 5;
	localparam logic [15:0] PosSat = 16'hFFFF;
	localparam int StallLimit = 2000;

	// score classes for random generation
	typedef enum int {
		ClsAny, ClsSmall, ClsNan, ClsInf, ClsZero, ClsNear
	} score_class_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	t5ss_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	t5ss_pkg::out_word_t out_data;

	logic [31:0] top_score [NumRanks];
	logic [15:0] top_pos [NumRanks];
	logic [15:0] next_pos;
	t5ss_pkg::out_word_t ranked_q [$];
	int err_count;
	int idle_cycles;
	bit gaps_on;
	logic [31:0] last_score;

	top5_score_select_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	// ordered IEEE greater-than on raw bits
	function automatic bit score_gt(logic [31:0] a, logic [31:0] b);
		bit a_nan;
		bit b_nan;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
		if (a_nan || b_nan) return 0;
		if (a[30:0] == 0 && b[30:0] == 0) return 0;
		if (a[31] != b[31]) return b[31];
		if (!a[31]) return a[30:0] > b[30:0];
		return a[30:0] < b[30:0];
	endfunction

	task automatic rank_score(t5ss_pkg::in_word_t w);
		logic [31:0] cs;
		logic [15:0] cp;
		logic [31:0] ts;
		logic [15:0] tp;
		t5ss_pkg::out_word_t r;
		if (w.first_of_vector) begin
			for (int j = 0; j < NumRanks; j++) begin
				top_score[j] = w.score_bits;
				top_pos[j] = 0;
			end
			next_pos = 0;
		end
		cs = w.score_bits;
		cp = next_pos;
		for (int j = 0; j < NumRanks; j++) begin
			if (score_gt(w.score_bits, top_score[j])) begin
				ts = top_score[j];
				tp = top_pos[j];
				top_score[j] = cs;
				top_pos[j] = cp;
				cs = ts;
				cp = tp;
			end
		end
		if (next_pos != PosSat) next_pos++;
		if (w.last_of_vector) begin
			r.rank1_pos = top_pos[0];
			r.rank2_pos = top_pos[1];
			r.rank3_pos = top_pos[2];
			r.rank4_pos = top_pos[3];
			r.rank5_pos = top_pos[4];
			r.rank1_score = top_score[0];
			r.rank2_score = top_score[1];
			r.rank3_score = top_score[2];
			r.rank4_score = top_score[3];
			r.rank5_score = top_score[4];
			ranked_q = {ranked_q, r};
		end
	endtask

	function automatic logic [31:0] pick_score();
		score_class_t c;
		logic [31:0] s;
		c = score_class_t'($urandom_range(0, 9) < 4 ? ClsSmall : $urandom_range(0, 5));
		s = $urandom;
		case (c)
			ClsSmall: s = {s[31], 8'd125 + 8'($urandom_range(0, 4)), 15'd0, s[7:0]};
			ClsNan: s = {s[31], 8'hFF, s[22:0] | 23'd1};
			ClsInf: s = {s[31], 8'hFF, 23'd0};
			ClsZero: s = {s[31], 31'd0};
			ClsNear: s = ($urandom_range(0, 1) != 0) ? last_score : last_score ^ 32'd1;
			default: ;
		endcase
		last_score = s;
		return s;
	endfunction

	// send one word; predict at acceptance; valid stays high into the next word
	task automatic send_word(logic [31:0] s, bit first, bit last);
		t5ss_pkg::in_word_t w;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		w.score_bits = s;
		w.first_of_vector = first;
		w.last_of_vector = last;
		in_data <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		rank_score(w);
		@(negedge clk);
	endtask

	task automatic send_vector(int len, bit with_first);
		for (int i = 0; i < len; i++)
			send_word(pick_score(), with_first && i == 0, i == len - 1);
	endtask

	// check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (ranked_q.size() == 0) begin
				$error("unexpected result word");
				err_count++;
			end else begin
				t5ss_pkg::out_word_t e;
				e = ranked_q.pop_front();
				if (e.rank1_pos !== out_data.rank1_pos) begin
					$error("rank1_pos exp %0d got %0d", e.rank1_pos, out_data.rank1_pos);
					err_count++;
				end
				if (e.rank2_pos !== out_data.rank2_pos) begin
					$error("rank2_pos exp %0d got %0d", e.rank2_pos, out_data.rank2_pos);
					err_count++;
				end
				if (e.rank3_pos !== out_data.rank3_pos) begin
					$error("rank3_pos exp %0d got %0d", e.rank3_pos, out_data.rank3_pos);
					err_count++;
				end
				if (e.rank4_pos !== out_data.rank4_pos) begin
					$error("rank4_pos exp %0d got %0d", e.rank4_pos, out_data.rank4_pos);
					err_count++;
				end
				if (e.rank5_pos !== out_data.rank5_pos) begin
					$error("rank5_pos exp %0d got %0d", e.rank5_pos, out_data.rank5_pos);
					err_count++;
				end
				if (e.rank1_score !== out_data.rank1_score) begin
					$error("rank1_score exp %h got %h", e.rank1_score, out_data.rank1_score);
					err_count++;
				end
				if (e.rank2_score !== out_data.rank2_score) begin
					$error("rank2_score exp %h got %h", e.rank2_score, out_data.rank2_score);
					err_count++;
				end
				if (e.rank3_score !== out_data.rank3_score) begin
					$error("rank3_score exp %h got %h", e.rank3_score, out_data.rank3_score);
					err_count++;
				end
				if (e.rank4_score !== out_data.rank4_score) begin
					$error("rank4_score exp %h got %h", e.rank4_score, out_data.rank4_score);
					err_count++;
				end
				if (e.rank5_score !== out_data.rank5_score) begin
					$error("rank5_score exp %h got %h", e.rank5_score, out_data.rank5_score);
					err_count++;
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic test_no_first_after_reset();
		send_word(32'hBF80_0000, 0, 0);
		send_word(32'h3F80_0000, 0, 0);
		send_word(32'h8000_0000, 0, 1);
		// keep accumulating past a last word
		send_word(32'h4000_0000, 0, 1);
	endtask

	task automatic test_special_scores();
		// NaN first keeps every slot
		send_word(32'h7FC0_0000, 1, 0);
		send_word(32'h3F80_0000, 0, 1);
		// zeros of both signs tie
		send_word(32'h0000_0000, 1, 0);
		send_word(32'h8000_0000, 0, 0);
		send_word(32'h0000_0001, 0, 0);
		send_word(32'hFFFF_FFFF, 0, 0);
		send_word(32'h7F80_0000, 0, 0);
		send_word(32'hFF80_0000, 0, 0);
		send_word(32'h7F7F_FFFF, 0, 0);
		send_word(32'h7F7F_FFFF, 0, 1);
		// single-word vector, most negative finite
		send_word(32'hFF7F_FFFF, 1, 1);
		// strictly rising run shifts everything down
		for (int i = 0; i < 7; i++)
			send_word(32'h3F80_0000 + 32'(i) * 32'h0010_0000, i == 0, i == 6);
		// equal scores at different positions keep their order when a larger one lands
		send_word(32'h3F80_0000, 1, 0);
		send_word(32'h4040_0000, 0, 0);
		send_word(32'h4040_0000, 0, 0);
		send_word(32'h40A0_0000, 0, 1);
	endtask

	task automatic test_random_vectors();
		int n;
		n = 0;
		while (n < 830) begin
			int len;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
			if (n > 700) gaps_on = 0;
			send_vector(len, $urandom_range(0, 9) != 0);
			n += len;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		err_count = 0;
		idle_cycles = 0;
		gaps_on = 1;
		last_score = 32'h3F80_0000;
		next_pos = 0;
		for (int j = 0; j < NumRanks; j++) begin
			top_score[j] = 0;
			top_pos[j] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_no_first_after_reset();
		test_special_scores();
		test_random_vectors();
		in_valid <= 1'b0;
		while (ranked_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0 && ranked_q.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
